// ===== hdl/lbc_pkg.sv =====
// Shared types and command/status codes of the block-buffer cache.
package lbc_pkg;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_COUNT    = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // cell update opcodes
  typedef enum logic [2:0] {
    UPD_NONE    = 3'd0,
    UPD_HIT     = 3'd1,
    UPD_RETAG   = 3'd2,
    UPD_INC     = 3'd3,
    UPD_DEC     = 3'd4,
    UPD_DEC_STP = 3'd5
  } upd_t;

  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int SLOT_W = 5;

  // cells per search segment; the chains are registered between segments
  localparam int SEG_CELLS = 8;

endpackage

// ===== hdl/lru_block_buffer_cache.sv =====
// Top level of the block-buffer tag cache with reference counts and LRU replacement.
// Usage:
//   in_* channel: one request per accepted beat. in_tdata carries command, device,
//   block_number and slot. The block works on one request at a time.
//   out_* channel: one result per request: slot_out, hit, need_read, status.
//   Search: the tag match and the oldest-free search ripple through the chain of
//   slot cells, SEG_CELLS cells per cycle, with the chains registered between
//   segments; 32 slots make 4 segments.
//   Order: a request is accepted into the hold registers, the search steps through
//   the segment registers, then the chosen cell updates and the result register loads
//   at the same edge, after which the result can be taken.
//   Requests: in_tready rises after the result loads, so a new request is not taken
//   before the result of the last one has loaded.
//   Reset: every slot is tagged device 0 / block 0, count 0, stamp 0, not valid;
//   the use clock restarts at 0. No clearing pass is needed.
//   Stall: while out_tready is low the result holds in the output register; one
//   more request may be accepted and searched, but its update waits until the
//   result register frees and in_tready stays low meanwhile, so nothing is lost.
module lru_block_buffer_cache #(
  parameter int BUFFER_SLOTS = 32,
  parameter int STAMP_BITS = 32,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [9:2] device, [41:10] block_number, [46:42] slot
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] slot_out, [5] hit, [6] need_read, [8:7] status
  output logic [15:0] out_tdata
);

  localparam int IDX_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam int SW = lbc_pkg::SLOT_W;
  localparam int SEG = lbc_pkg::SEG_CELLS;
  localparam int NSEG = (BUFFER_SLOTS + SEG - 1) / SEG;
  localparam int NCUT = (NSEG > 1) ? NSEG - 1 : 1;
  localparam int PH_W = (NSEG > 1) ? $clog2(NSEG) : 1;

  // hold the accepted request
  logic                        busy_r;
  logic [PH_W-1:0]             phase_r;
  logic [1:0]                  cmd_r;
  logic [lbc_pkg::DEV_W-1:0]   dev_r;
  logic [lbc_pkg::BLK_W-1:0]   blk_r;
  logic [SW-1:0]               slot_r;
  logic [STAMP_BITS-1:0]       clock_r;
  logic                        out_valid_r;
  logic [15:0]                 out_data_r;

  // chains: *_c feeds cell g, *_o leaves cell g
  logic                        hit_c [BUFFER_SLOTS];
  logic [IDX_W-1:0]            hidx_c [BUFFER_SLOTS];
  logic                        free_c [BUFFER_SLOTS];
  logic [IDX_W-1:0]            fidx_c [BUFFER_SLOTS];
  logic [STAMP_BITS-1:0]       fstamp_c [BUFFER_SLOTS];
  logic                        hit_o [BUFFER_SLOTS];
  logic [IDX_W-1:0]            hidx_o [BUFFER_SLOTS];
  logic                        free_o [BUFFER_SLOTS];
  logic [IDX_W-1:0]            fidx_o [BUFFER_SLOTS];
  logic [STAMP_BITS-1:0]       fstamp_o [BUFFER_SLOTS];
  // chain values held between segments
  logic                        hit_seg_r [NCUT];
  logic [IDX_W-1:0]            hidx_seg_r [NCUT];
  logic                        free_seg_r [NCUT];
  logic [IDX_W-1:0]            fidx_seg_r [NCUT];
  logic [STAMP_BITS-1:0]       fstamp_seg_r [NCUT];
  logic [COUNT_BITS-1:0]       cnt_w [BUFFER_SLOTS];
  logic                        valid_w [BUFFER_SLOTS];
  logic                        sel_w [BUFFER_SLOTS];

  logic                        last_phase;
  logic                        issue;
  logic                        do_upd;
  logic                        any_hit;
  logic                        any_free;
  logic [IDX_W-1:0]            tgt_idx;
  lbc_pkg::upd_t               op;
  logic                        stamp_adv;
  logic [SW-1:0]               res_slot;
  logic                        res_hit, res_need;
  lbc_pkg::status_t            res_st;
  logic [COUNT_BITS-1:0]       sel_cnt;
  logic                        sel_valid;
  logic                        slot_ok;

  // the output register parts the two sides: accept whenever no request is held
  assign in_tready = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign last_phase = (phase_r == PH_W'(NSEG - 1));
  // update the cells and load the result once the search is through and the
  // result register is free or being emptied
  assign issue = busy_r && last_phase && (!out_valid_r || out_tready);

  assign any_hit = hit_o[BUFFER_SLOTS-1];
  assign any_free = free_o[BUFFER_SLOTS-1];

  for (genvar g = 0; g < BUFFER_SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign hit_c[g] = 1'b0;
      assign hidx_c[g] = '0;
      assign free_c[g] = 1'b0;
      assign fidx_c[g] = '0;
      assign fstamp_c[g] = '0;
    end else if ((g % SEG) == 0) begin : g_cut
      assign hit_c[g] = hit_seg_r[g / SEG - 1];
      assign hidx_c[g] = hidx_seg_r[g / SEG - 1];
      assign free_c[g] = free_seg_r[g / SEG - 1];
      assign fidx_c[g] = fidx_seg_r[g / SEG - 1];
      assign fstamp_c[g] = fstamp_seg_r[g / SEG - 1];
    end else begin : g_pass
      assign hit_c[g] = hit_o[g-1];
      assign hidx_c[g] = hidx_o[g-1];
      assign free_c[g] = free_o[g-1];
      assign fidx_c[g] = fidx_o[g-1];
      assign fstamp_c[g] = fstamp_o[g-1];
    end
    assign sel_w[g] = do_upd && (tgt_idx == IDX_W'(g));
    lbc_cell #(
      .IDX_W(IDX_W), .STAMP_BITS(STAMP_BITS), .COUNT_BITS(COUNT_BITS), .MY_IDX(g)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .key_dev(dev_r), .key_blk(blk_r),
      .hit_in(hit_c[g]), .hit_idx_in(hidx_c[g]),
      .hit_out(hit_o[g]), .hit_idx_out(hidx_o[g]),
      .free_in(free_c[g]), .free_idx_in(fidx_c[g]), .free_stamp_in(fstamp_c[g]),
      .free_out(free_o[g]), .free_idx_out(fidx_o[g]),
      .free_stamp_out(fstamp_o[g]),
      .upd_sel(sel_w[g]), .upd_op(op), .upd_stamp(clock_r),
      .count(cnt_w[g]), .valid(valid_w[g])
    );
  end

  // advance the search one segment per cycle; the key and the cells hold still
  // while a request is busy, so each cut settles in the cycle after the one below
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSEG - 1; k++) begin
      hit_seg_r[k] <= hit_o[(k + 1) * SEG - 1];
      hidx_seg_r[k] <= hidx_o[(k + 1) * SEG - 1];
      free_seg_r[k] <= free_o[(k + 1) * SEG - 1];
      fidx_seg_r[k] <= fidx_o[(k + 1) * SEG - 1];
      fstamp_seg_r[k] <= fstamp_o[(k + 1) * SEG - 1];
    end
  end

  // decide the outcome of the held request
  always_comb begin
    op = lbc_pkg::UPD_NONE;
    tgt_idx = '0;
    stamp_adv = 1'b0;
    res_slot = slot_r;
    res_hit = 1'b0;
    res_need = 1'b0;
    res_st = lbc_pkg::ST_OK;
    slot_ok = ({{(32-SW){1'b0}}, slot_r} < 32'(BUFFER_SLOTS));
    if (cmd_r == lbc_pkg::CMD_ACQUIRE) begin
      tgt_idx = any_hit ? hidx_o[BUFFER_SLOTS-1] : fidx_o[BUFFER_SLOTS-1];
    end else begin
      tgt_idx = IDX_W'(slot_r);
    end
    sel_cnt = cnt_w[tgt_idx];
    sel_valid = valid_w[tgt_idx];
    unique case (cmd_r)
      lbc_pkg::CMD_ACQUIRE: begin
        if (any_hit) begin
          res_slot = SW'(tgt_idx);
          res_hit = 1'b1;
          if (sel_cnt == '1) begin
            res_st = lbc_pkg::ST_COUNT;
          end else begin
            op = lbc_pkg::UPD_HIT;
            stamp_adv = 1'b1;
            res_need = !sel_valid;
          end
        end else if (any_free) begin
          res_slot = SW'(tgt_idx);
          res_need = 1'b1;
          op = lbc_pkg::UPD_RETAG;
          stamp_adv = 1'b1;
        end else begin
          res_slot = '0;
          res_st = lbc_pkg::ST_NO_FREE;
        end
      end
      lbc_pkg::CMD_PIN: begin
        if (!slot_ok || sel_cnt == '1) res_st = lbc_pkg::ST_COUNT;
        else op = lbc_pkg::UPD_INC;
      end
      lbc_pkg::CMD_RELEASE, lbc_pkg::CMD_UNPIN: begin
        if (!slot_ok || sel_cnt == '0) begin
          res_st = lbc_pkg::ST_COUNT;
        end else if (cmd_r == lbc_pkg::CMD_RELEASE) begin
          op = lbc_pkg::UPD_DEC_STP;
          stamp_adv = 1'b1;
        end else begin
          op = lbc_pkg::UPD_DEC;
        end
      end
      default: ;
    endcase
  end

  assign do_upd = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      phase_r <= '0;
      out_valid_r <= 1'b0;
      clock_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
        phase_r <= '0;
      end else if (issue) begin
        busy_r <= 1'b0;
      end else if (busy_r && !last_phase) begin
        phase_r <= phase_r + 1'b1;
      end
      if (issue) begin
        out_valid_r <= 1'b1;
        if (stamp_adv) clock_r <= clock_r + 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[1:0];
      dev_r <= in_tdata[9:2];
      blk_r <= in_tdata[41:10];
      slot_r <= in_tdata[46:42];
    end
    if (issue) begin
      out_data_r <= {7'd0, res_st, res_need, res_hit, res_slot};
    end
  end

  // a running search blocks new requests
  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready) else $error("request taken during a search");
  // a stalled result holds its value
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result changed while stalled");
  // use clock advances only as a request completes
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> $stable(clock_r)) else $error("clock moved while idle");

endmodule

// ===== hdl/lbc_cell.sv =====
// One buffer slot: tag, count, stamp, valid bit, and one step of the search chains.
module lbc_cell #(
  parameter int IDX_W = 5,
  parameter int STAMP_BITS = 32,
  parameter int COUNT_BITS = 8,
  parameter int MY_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lbc_pkg::DEV_W-1:0]  key_dev,
  input  logic [lbc_pkg::BLK_W-1:0]  key_blk,
  // hit chain from lower neighbor
  input  logic                       hit_in,
  input  logic [IDX_W-1:0]           hit_idx_in,
  output logic                       hit_out,
  output logic [IDX_W-1:0]           hit_idx_out,
  // oldest-free chain from lower neighbor
  input  logic                       free_in,
  input  logic [IDX_W-1:0]           free_idx_in,
  input  logic [STAMP_BITS-1:0]      free_stamp_in,
  output logic                       free_out,
  output logic [IDX_W-1:0]           free_idx_out,
  output logic [STAMP_BITS-1:0]      free_stamp_out,
  // update
  input  logic                       upd_sel,
  input  lbc_pkg::upd_t              upd_op,
  input  logic [STAMP_BITS-1:0]      upd_stamp,
  output logic [COUNT_BITS-1:0]      count,
  output logic                       valid
);

  logic [lbc_pkg::DEV_W-1:0] dev_r;
  logic [lbc_pkg::BLK_W-1:0] blk_r;
  logic [COUNT_BITS-1:0]     cnt_r;
  logic [STAMP_BITS-1:0]     stamp_r;
  logic                      valid_r;
  logic                      match;
  logic                      take_free;

  assign match = (dev_r == key_dev) && (blk_r == key_blk);
  assign hit_out = hit_in | match;
  assign hit_idx_out = hit_in ? hit_idx_in : IDX_W'(MY_IDX);

  assign take_free = (cnt_r == '0) && (!free_in || (stamp_r < free_stamp_in));
  assign free_out = free_in | (cnt_r == '0);
  assign free_idx_out = take_free ? IDX_W'(MY_IDX) : free_idx_in;
  assign free_stamp_out = take_free ? stamp_r : free_stamp_in;

  assign count = cnt_r;
  assign valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= '0;
      blk_r <= '0;
      cnt_r <= '0;
      stamp_r <= '0;
      valid_r <= 1'b0;
    end else if (upd_sel) begin
      case (upd_op)
        lbc_pkg::UPD_HIT: begin
          cnt_r <= cnt_r + 1'b1;
          stamp_r <= upd_stamp;
          valid_r <= 1'b1;
        end
        lbc_pkg::UPD_RETAG: begin
          dev_r <= key_dev;
          blk_r <= key_blk;
          cnt_r <= COUNT_BITS'(1);
          stamp_r <= upd_stamp;
          valid_r <= 1'b1;
        end
        lbc_pkg::UPD_INC: cnt_r <= cnt_r + 1'b1;
        lbc_pkg::UPD_DEC: cnt_r <= cnt_r - 1'b1;
        lbc_pkg::UPD_DEC_STP: begin
          cnt_r <= cnt_r - 1'b1;
          stamp_r <= upd_stamp;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/lbc_checker.sv =====
// Result predictor and scoreboard for the block-buffer cache channels.
`timescale 1ns / 1ps
module lbc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int SLOTS = 32;
  localparam logic [7:0] COUNT_TOP = 8'hFF;

  typedef struct packed {
    logic [1:0]                 status;
    logic                       need_read;
    logic                       hit;
    logic [lbc_pkg::SLOT_W-1:0] slot_out;
  } cache_result_t;

  logic [lbc_pkg::DEV_W-1:0] tag_dev[SLOTS];
  logic [lbc_pkg::BLK_W-1:0] tag_blk[SLOTS];
  logic [7:0]       refs[SLOTS];
  logic [31:0]      last_stamp[SLOTS];
  logic             loaded[SLOTS];
  logic [31:0]      use_clk;
  cache_result_t    result_q[$];

  assign pending = result_q.size();

  task automatic touch(input int i);
    last_stamp[i] = use_clk;
    use_clk = use_clk + 32'd1;
  endtask

  task automatic predict_result(input logic [47:0] req, output cache_result_t r);
    lbc_pkg::cmd_t cmd;
    logic [lbc_pkg::DEV_W-1:0] dev;
    logic [lbc_pkg::BLK_W-1:0] blk;
    logic [lbc_pkg::SLOT_W-1:0] s;
    int found;
    cmd = lbc_pkg::cmd_t'(req[1:0]);
    dev = req[9:2];
    blk = req[41:10];
    s = req[46:42];
    found = -1;
    r = '0;
    if (cmd == lbc_pkg::CMD_ACQUIRE) begin
      for (int i = 0; i < SLOTS; i++)
        if (found < 0 && tag_dev[i] == dev && tag_blk[i] == blk) found = i;
      if (found >= 0) begin
        r.slot_out = found[lbc_pkg::SLOT_W-1:0];
        r.hit = 1'b1;
        if (refs[found] == COUNT_TOP) begin
          r.status = lbc_pkg::ST_COUNT;
        end else begin
          refs[found]++;
          touch(found);
          r.need_read = !loaded[found];
          loaded[found] = 1'b1;
          r.status = lbc_pkg::ST_OK;
        end
      end else begin
        // oldest free slot, ties to the lowest index
        for (int i = 0; i < SLOTS; i++)
          if (refs[i] == 0 && (found < 0 || last_stamp[i] < last_stamp[found])) found = i;
        if (found < 0) begin
          r.status = lbc_pkg::ST_NO_FREE;
        end else begin
          tag_dev[found] = dev;
          tag_blk[found] = blk;
          refs[found] = 8'd1;
          touch(found);
          loaded[found] = 1'b1;
          r.slot_out = found[lbc_pkg::SLOT_W-1:0];
          r.need_read = 1'b1;
          r.status = lbc_pkg::ST_OK;
        end
      end
    end else begin
      r.slot_out = s;
      if (cmd == lbc_pkg::CMD_PIN) begin
        if (refs[s] == COUNT_TOP) r.status = lbc_pkg::ST_COUNT;
        else refs[s]++;
      end else begin
        if (refs[s] == 0) begin
          r.status = lbc_pkg::ST_COUNT;
        end else begin
          refs[s]--;
          if (cmd == lbc_pkg::CMD_RELEASE) touch(s);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i] = '0;
        last_stamp[i] = '0;
        loaded[i] = 1'b0;
      end
      use_clk = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_result(in_tdata, want);
        result_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[8:0];
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (got.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
            fail_count++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            fail_count++;
          end
          if (got.need_read !== want.need_read) begin
            $error("need_read: expected %0d, got %0d", want.need_read, got.need_read);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top: drives requests, stalls the result side and reports the verdict.
`timescale 1ns / 1ps
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [1:0] command, [9:2] device, [41:10] block_number, [46:42] slot
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [4:0] slot_out, [5] hit, [6] need_read, [8:7] status
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending;
  int          burst_left;
  bit          hold_off;

  lru_block_buffer_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lbc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  // Stall the result side on its own pattern; hold off once for a long stretch.
  initial begin
    out_tready = 1'b0;
    hold_off = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_tready <= ($urandom_range(0, 2) == 0);
      else out_tready <= 1'b1;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    @(posedge clk iff rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    // hold the output back while the sender keeps offering requests
    while (cycles < 200) begin
      @(posedge clk);
      cycles++;
    end
    hold_off = 1'b0;
  end

  // Offer one request and wait for its acceptance; sometimes idle between bursts.
  task automatic send(input lbc_pkg::cmd_t cmd, input logic [lbc_pkg::DEV_W-1:0] dev,
                      input logic [lbc_pkg::BLK_W-1:0] blk,
                      input logic [lbc_pkg::SLOT_W-1:0] s);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, s, blk, dev, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int n;
    logic [lbc_pkg::SLOT_W-1:0] s;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset tag hit, field extremes, underflow on release and unpin.
    send(lbc_pkg::CMD_ACQUIRE, 8'h00, 32'h0, 5'd0);
    send(lbc_pkg::CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send(lbc_pkg::CMD_ACQUIRE, 8'h00, 32'h0, 5'd0);
    send(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0);
    send(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0);
    send(lbc_pkg::CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    send(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd31);
    send(lbc_pkg::CMD_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send(lbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd31);
    send(lbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd31);
    send(lbc_pkg::CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    send(lbc_pkg::CMD_ACQUIRE, 8'hA5, 32'h5A5A_A5A5, 5'd21);
    send(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd1);

    // Fill every free slot with fresh blocks, then four more to find no free slot.
    for (int i = 0; i < 34; i++) send(lbc_pkg::CMD_ACQUIRE, 8'd7, 32'h1000 + i, 5'd0);

    // Drive one slot's count past the top through pins, then three acquires.
    s = (lbc_pkg::SLOT_W)'($urandom_range(0, 31));
    for (int i = 0; i < 256; i++) send(lbc_pkg::CMD_PIN, 8'd0, 32'd0, s);
    for (int i = 0; i < 3; i++) send(lbc_pkg::CMD_ACQUIRE, 8'd7, 32'h1000 + s, 5'd0);
    for (int i = 0; i < 32; i++)
      repeat (2) send(lbc_pkg::CMD_UNPIN, 8'd0, 32'd0, i[lbc_pkg::SLOT_W-1:0]);

    // Random: mostly acquires and releases over a small block pool so hits recur.
    n = 0;
    while (n < 230) begin
      lbc_pkg::cmd_t c;
      logic [lbc_pkg::DEV_W-1:0] dev;
      logic [lbc_pkg::BLK_W-1:0] blk;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: c = lbc_pkg::CMD_ACQUIRE;
        5, 6, 7: c = lbc_pkg::CMD_RELEASE;
        8: c = lbc_pkg::CMD_PIN;
        default: c = lbc_pkg::CMD_UNPIN;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        dev = (lbc_pkg::DEV_W)'($urandom);
        blk = $urandom;
      end else begin
        dev = (lbc_pkg::DEV_W)'($urandom_range(0, 2));
        blk = $urandom_range(0, 40);
      end
      send(c, dev, blk, (lbc_pkg::SLOT_W)'($urandom_range(0, 31)));
      n++;
    end
    in_tvalid <= 1'b0;

    // Drain, then keep waiting for stray results.
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// ===== lru_block_buffer_cache.f =====
hdl/lbc_pkg.sv
hdl/lbc_cell.sv
hdl/lru_block_buffer_cache.sv
dv/lbc_checker.sv
dv/tb.sv
